@@ rtl/osst_pkg.sv @@
// package for the ordered set store
// command codes, fsm state type and the cell control struct; no dependencies
package osst_pkg;

    localparam int CAPACITY_DEF     = 64;
    localparam int ELEMENT_BITS_DEF = 16;
    localparam int VALUE_W          = 16;
    localparam int COUNT_OUT_W      = 7;
    localparam int CMD_W            = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic cmp;
        logic del;
        logic ins;
    } t_cell_ctl;

endpackage

@@ rtl/osst_cell.sv @@
// one slot of the ordered set store: holds an element, compares it, shifts on delete
// and loads the value on insert at the end; depends on osst_pkg
module osst_cell
    import osst_pkg::*;
#(
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic [ELEMENT_BITS-1:0] i_value,
    input  logic                    i_live,
    input  logic                    i_at_end,
    input  logic [ELEMENT_BITS-1:0] i_next,
    input  logic                    i_seen,
    output logic [ELEMENT_BITS-1:0] o_slot,
    output logic                    o_seen
);

    logic [ELEMENT_BITS-1:0] r_slot;
    logic [ELEMENT_BITS-1:0] n_slot;
    logic                    r_match;
    logic                    n_match;

    assign o_slot = r_slot;
    assign o_seen = i_seen | r_match;

    always_comb begin
        n_match = r_match;
        if (i_ctl.cmp) begin
            n_match = i_live && (r_slot == i_value);
        end
    end

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.del && o_seen) begin
            n_slot = i_next;
        end else if (i_ctl.ins && i_at_end) begin
            n_slot = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_match <= n_match;
    end

endmodule

@@ rtl/ordered_set_store.sv @@
// ordered set store: a row of slot cells, a match-flag chain and the count register
// an item is compared while idle, then updated/shifted in S_UPDATE while busy blocks new
// items; the result strobe is registered from S_UPDATE. results cannot be stalled.
// synchronous active-low reset clears count, fsm and strobe; slot contents stay undefined
// depends on osst_pkg and osst_cell
module ordered_set_store
    import osst_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [VALUE_W-1:0]     i_value,
    output logic                   busy,
    output logic                   o_valid,
    output logic                   o_was_member,
    output logic [COUNT_OUT_W-1:0] o_count_after,
    output logic                   o_full_res,
    output logic                   o_empty_res,
    output logic                   o_dropped
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_state                  r_state;
    t_state                  n_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [CMD_W-1:0]        r_cmd;
    logic [ELEMENT_BITS-1:0] r_val;
    logic                    r_done;
    logic                    r_was_member;
    logic [CW-1:0]           r_count_out;
    logic                    r_dropped;

    logic                    accept;
    logic                    in_update;
    logic [ELEMENT_BITS-1:0] in_elem;
    logic [ELEMENT_BITS+VALUE_W-1:0] in_ext;
    logic [ELEMENT_BITS-1:0] cell_value;
    logic                    present;
    logic                    room;
    logic                    del_go;
    logic                    ins_go;
    logic                    drop;
    t_cell_ctl               ctl;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    logic [ELEMENT_BITS-1:0] slot [CAPACITY];
    logic [CAPACITY:0]       seen;

    assign accept     = start && !busy;
    assign in_ext     = {{ELEMENT_BITS{1'b0}}, i_value};
    assign in_elem    = in_ext[ELEMENT_BITS-1:0];
    assign cell_value = in_update ? r_val : in_elem;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy      = 1'b0;
        in_update = 1'b0;
        case (r_state)
            S_IDLE:   busy = 1'b0;
            S_UPDATE: begin
                busy      = 1'b1;
                in_update = 1'b1;
            end
            default:  busy = 1'b0;
        endcase
    end

    assign present = seen[CAPACITY];
    assign room    = r_count < CW'(CAPACITY);

    always_comb begin
        del_go = 1'b0;
        ins_go = 1'b0;
        drop   = 1'b0;
        if (in_update) begin
            case (r_cmd)
                CMD_INSERT: begin
                    ins_go = !present && room;
                    drop   = !present && !room;
                end
                CMD_DELETE: del_go = present;
                default:    del_go = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        if (ins_go) begin
            n_count = r_count + CW'(1);
        end else if (del_go) begin
            n_count = r_count - CW'(1);
        end
    end

    assign ctl.cmp = accept;
    assign ctl.del = del_go;
    assign ctl.ins = ins_go;

    assign seen[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEMENT_BITS-1:0] next_slot;
        if (g == CAPACITY - 1) begin : g_last
            assign next_slot = slot[g];
        end else begin : g_mid
            assign next_slot = slot[g+1];
        end
        osst_cell #(
            .ELEMENT_BITS(ELEMENT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_value (cell_value),
            .i_live  (CW'(g) < r_count),
            .i_at_end(CW'(g) == r_count),
            .i_next  (next_slot),
            .i_seen  (seen[g]),
            .o_slot  (slot[g]),
            .o_seen  (seen[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= in_update;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_val <= in_elem;
        end
        if (in_update) begin
            r_was_member <= present;
            r_count_out  <= n_count;
            r_dropped    <= drop;
        end
    end

    assign count_ext     = {{COUNT_OUT_W{1'b0}}, r_count_out};
    assign o_valid       = r_done;
    assign o_was_member  = r_was_member;
    assign o_count_after = count_ext[COUNT_OUT_W-1:0];
    assign o_full_res    = r_count_out == CW'(CAPACITY);
    assign o_empty_res   = r_count_out == '0;
    assign o_dropped     = r_dropped;

endmodule

@@ rtl/osst_checker.sv @@
// port-level checks for the ordered set store and the bind that attaches them
// depends on osst_pkg and ordered_set_store
module osst_checker
    import osst_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_valid,
    input logic                   o_was_member,
    input logic [COUNT_OUT_W-1:0] o_count_after,
    input logic                   o_full_res,
    input logic                   o_empty_res,
    input logic                   o_dropped
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy) && !busy)
        else $error("result strobe without a preceding update cycle");

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_full_res && o_empty_res))
        else $error("result flagged both full and empty");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dropped |-> o_full_res && !o_was_member)
        else $error("dropped insert without a full set or with a present value");

endmodule

bind ordered_set_store osst_checker u_osst_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// testbench for ordered_set_store: directed table then phased random traffic,
// every result checked against its table row where typed, else an in-bench set model
// depends on osst_pkg and the ordered_set_store rtl
module tb;
    import osst_pkg::*;

    localparam int SET_CAP = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 800;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic                   was_member;
        logic [COUNT_OUT_W-1:0] count;
        logic                   full;
        logic                   empty;
        logic                   dropped;
    } t_set_result;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic               typed;
        t_set_result        res;
    } t_stim_row;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_MIXED,
        MIX_FILL,
        MIX_DRAIN
    } t_mix_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [CMD_W-1:0]       i_command = CMD_QUERY;
    logic [VALUE_W-1:0]     i_value = '0;
    logic                   busy;
    logic                   o_valid;
    logic                   o_was_member;
    logic [COUNT_OUT_W-1:0] o_count_after;
    logic                   o_full_res;
    logic                   o_empty_res;
    logic                   o_dropped;

    logic [VALUE_W-1:0] members[$];
    t_set_result        pending[$];
    logic               typed_ok = 1'b0;
    t_set_result        typed_res = '0;
    int                 n_errors = 0;
    int                 n_accepted = 0;
    int                 n_results = 0;
    int                 n_refused = 0;
    int                 n_full_seen = 0;
    int                 peak_size = 0;

    t_stim_row dir_rows [0:20] = '{
        '{CMD_QUERY,  16'h0000, 1'b1, '{1'b0, 7'd0, 1'b0, 1'b1, 1'b0}},
        '{CMD_DELETE, 16'hFFFF, 1'b1, '{1'b0, 7'd0, 1'b0, 1'b1, 1'b0}},
        '{CMD_INSERT, 16'h0000, 1'b1, '{1'b0, 7'd1, 1'b0, 1'b0, 1'b0}},
        '{CMD_INSERT, 16'hFFFF, 1'b1, '{1'b0, 7'd2, 1'b0, 1'b0, 1'b0}},
        '{CMD_INSERT, 16'h0000, 1'b1, '{1'b1, 7'd2, 1'b0, 1'b0, 1'b0}},
        '{CMD_QUERY,  16'hFFFF, 1'b1, '{1'b1, 7'd2, 1'b0, 1'b0, 1'b0}},
        '{CMD_SPARE,  16'hFFFF, 1'b1, '{1'b1, 7'd2, 1'b0, 1'b0, 1'b0}},
        '{CMD_SPARE,  16'h1234, 1'b1, '{1'b0, 7'd2, 1'b0, 1'b0, 1'b0}},
        '{CMD_INSERT, 16'hAAAA, 1'b0, '0},
        '{CMD_INSERT, 16'h5555, 1'b0, '0},
        '{CMD_DELETE, 16'h0000, 1'b0, '0},
        '{CMD_QUERY,  16'hFFFF, 1'b0, '0},
        '{CMD_DELETE, 16'hAAAA, 1'b0, '0},
        '{CMD_DELETE, 16'hAAAA, 1'b1, '{1'b0, 7'd2, 1'b0, 1'b0, 1'b0}},
        '{CMD_DELETE, 16'h5555, 1'b0, '0},
        '{CMD_INSERT, 16'h8000, 1'b0, '0},
        '{CMD_DELETE, 16'hFFFF, 1'b0, '0},
        '{CMD_DELETE, 16'h8000, 1'b1, '{1'b1, 7'd0, 1'b0, 1'b1, 1'b0}},
        '{CMD_QUERY,  16'h8000, 1'b1, '{1'b0, 7'd0, 1'b0, 1'b1, 1'b0}},
        '{CMD_INSERT, 16'h0001, 1'b0, '0},
        '{CMD_INSERT, 16'h7FFE, 1'b0, '0}
    };

    ordered_set_store i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_command     (i_command),
        .i_value       (i_value),
        .busy          (busy),
        .o_valid       (o_valid),
        .o_was_member  (o_was_member),
        .o_count_after (o_count_after),
        .o_full_res    (o_full_res),
        .o_empty_res   (o_empty_res),
        .o_dropped     (o_dropped)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_set_result apply_set_op(logic [CMD_W-1:0] cmd,
                                                 logic [VALUE_W-1:0] value);
        t_set_result r;
        int pos;
        r = '0;
        pos = members.size();
        for (int k = members.size() - 1; k >= 0; k--) begin
            if (members[k] == value) pos = k;
        end
        r.was_member = pos < members.size();
        case (cmd)
            CMD_INSERT: begin
                if (!r.was_member) begin
                    if (members.size() >= SET_CAP) r.dropped = 1'b1;
                    else members.push_back(value);
                end
            end
            CMD_DELETE: begin
                if (r.was_member) members.delete(pos);
            end
            default: ;
        endcase
        r.count = COUNT_OUT_W'(members.size());
        r.full = members.size() == SET_CAP;
        r.empty = members.size() == 0;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("mismatch: %s expected %0h got %0h at result %0d (t=%0t)",
                 field, want, got, n_results, $realtime);
        n_errors++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_set_result got;
        t_set_result want;
        t_set_result pred;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                got = {o_was_member, o_count_after, o_full_res, o_empty_res, o_dropped};
                if (pending.size() == 0) begin
                    report_mismatch("unexpected result, pending count", 0, 1);
                end else begin
                    want = pending.pop_front();
                    if (got.was_member !== want.was_member)
                        report_mismatch("was_member", want.was_member, got.was_member);
                    if (got.count !== want.count)
                        report_mismatch("count_after", want.count, got.count);
                    if (got.full !== want.full)
                        report_mismatch("full_res", want.full, got.full);
                    if (got.empty !== want.empty)
                        report_mismatch("empty_res", want.empty, got.empty);
                    if (got.dropped !== want.dropped)
                        report_mismatch("dropped", want.dropped, got.dropped);
                end
                n_results++;
            end
            if (start && busy === 1'b0) begin
                pred = apply_set_op(i_command, i_value);
                pending.push_back(typed_ok ? typed_res : pred);
                n_accepted++;
                if (pred.dropped) n_refused++;
                if (pred.full) n_full_seen++;
                if (members.size() > peak_size) peak_size = members.size();
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                             input logic typed, input t_set_result res);
        @(negedge i_clk);
        start <= 1'b1;
        i_command <= cmd;
        i_value <= value;
        typed_ok = typed;
        typed_res = res;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int sent;
        int phase;
        int plen;
        int r;
        int ins_pct;
        int del_pct;
        bit calm;
        t_mix_mode mode;
        logic [CMD_W-1:0] cmd;
        logic [VALUE_W-1:0] value;
        sent = 0;
        phase = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            send_item(dir_rows[k].cmd, dir_rows[k].value, dir_rows[k].typed, dir_rows[k].res);
        end
        wait_drained();

        while (sent < RANDOM_ITEMS) begin
            if (phase == 0) mode = MIX_FILL;
            else if (phase == 1) mode = MIX_DRAIN;
            else begin
                case ($urandom_range(0, 5))
                    0: mode = MIX_GROW;
                    1: mode = MIX_SHRINK;
                    3: mode = MIX_FILL;
                    4: mode = MIX_DRAIN;
                    default: mode = MIX_MIXED;
                endcase
            end
            case (mode)
                MIX_FILL: plen = SET_CAP - members.size() + 12;
                MIX_DRAIN: plen = members.size() + 6;
                default: plen = $urandom_range(30, 90);
            endcase
            ins_pct = (mode == MIX_GROW) ? 65 : (mode == MIX_SHRINK) ? 15 : 35;
            del_pct = (mode == MIX_GROW) ? 15 : (mode == MIX_SHRINK) ? 65 : 30;
            calm = (phase == 2);
            for (int n = 0; n < plen && sent < RANDOM_ITEMS; n++) begin
                if (!calm && $urandom_range(0, 99) < 33) hold_off($urandom_range(1, 4));
                r = $urandom_range(0, 99);
                if (mode == MIX_FILL) begin
                    cmd = CMD_INSERT;
                    if (members.size() == SET_CAP && r < 40)
                        value = members[$urandom_range(0, members.size() - 1)];
                    else
                        value = VALUE_W'($urandom_range(0, 16'hFFFF));
                end else if (mode == MIX_DRAIN) begin
                    cmd = CMD_DELETE;
                    if (members.size() > 0)
                        value = members[$urandom_range(0, members.size() - 1)];
                    else
                        value = VALUE_W'($urandom_range(0, 16'hFFFF));
                end else begin
                    if (r < ins_pct) cmd = CMD_INSERT;
                    else if (r < ins_pct + del_pct) cmd = CMD_DELETE;
                    else if (r < 95) cmd = CMD_QUERY;
                    else cmd = CMD_SPARE;
                    r = $urandom_range(0, 99);
                    if (members.size() > 0 && r < 50)
                        value = members[$urandom_range(0, members.size() - 1)];
                    else if (r < 65)
                        value = VALUE_W'($urandom_range(0, 15));
                    else
                        value = VALUE_W'($urandom_range(0, 16'hFFFF));
                end
                send_item(cmd, value, 1'b0, '0);
                sent++;
            end
            if (phase % 4 == 3) wait_drained();
            phase++;
        end

        @(negedge i_clk);
        start <= 1'b0;
        for (int t = 0; t < 200 && pending.size() != 0; t++) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (pending.size() != 0) report_mismatch("results missing at end", 0, pending.size());

        $display("tb: %0d items accepted, %0d results checked over %0d phases",
                 n_accepted, n_results, phase);
        $display("tb: peak set size %0d, %0d results at capacity, %0d refused inserts",
                 peak_size, n_full_seen, n_refused);
        if (n_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
